// ===== src/ogp_pkg.sv =====
// Shared types and constants for the occupancy grid painter.
// Holds the command, result and work descriptor structs and the grid sizing.
// No dependencies.
package ogp_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  localparam int OPC_W  = 3;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 8;
  localparam int RAD_W  = 11;
  localparam int SIZE_W = 7;

  // Signed coordinate width: holds a position plus a length or radius.
  localparam int CRD_W = POS_W + 2;
  localparam int RSQ_W = 2 * RAD_W;
  localparam int LIM_W = RSQ_W - 8;
  localparam int HW_W  = (LIM_W + 1) / 2;
  localparam int SQ_W  = LIM_W + 1;
  localparam int DY_W  = POS_W;
  localparam int DSQ_W = 2 * DY_W;
  localparam int T_W   = ((LIM_W > DSQ_W) ? LIM_W : DSQ_W) + 1;

  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] MAP_WIDTH_RST  = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] MAP_HEIGHT_RST = SIZE_W'(64);

  localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);
  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2 * HW_W - 2);

  typedef enum logic [OPC_W-1:0] {
    OP_QUERY       = 3'd0,
    OP_SET_POINT   = 3'd1,
    OP_CLEAR_POINT = 3'd2,
    OP_FILL_RECT   = 3'd3,
    OP_CLEAR_RECT  = 3'd4,
    OP_FILL_DISC   = 3'd5,
    OP_CLEAR_DISC  = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    K_QUERY = 2'd0,
    K_RECT  = 2'd1,
    K_DISC  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [LEN_W-1:0]        rect_width;
    logic [LEN_W-1:0]        rect_height;
    logic [RAD_W-1:0]        disc_radius;
  } cmd_t;

  typedef struct packed {
    logic inside_map;
    logic walkable;
  } res_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    value;
    logic [ROW_CNT_W-1:0]    row_lo;
    logic [ROW_CNT_W-1:0]    row_hi;
    logic signed [CRD_W-1:0] col_lo;
    logic signed [CRD_W-1:0] col_hi;
    logic [COL_CNT_W-1:0]    col_max;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [LIM_W-1:0]        lim;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

endpackage

// ===== src/ogp_front.sv =====
// Front end: takes commands, holds the map size registers and turns each
// command into a clipped work descriptor for the queue. Depends on ogp_pkg.
module ogp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ogp_pkg::cmd_t                  in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ogp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogp_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic                           q_full,
  output ogp_pkg::push_t                 push
);
  import ogp_pkg::*;

  logic                    full_r, full_nxt;
  cmd_t                    cmd_r;
  logic [SIZE_W-1:0]       width_r, height_r;
  logic [COL_CNT_W-1:0]    cols;
  logic [ROW_CNT_W-1:0]    rows;
  logic signed [CRD_W-1:0] cols_s, rows_s, x, y, w, h, r16;
  logic [RSQ_W-1:0]        rad_sq;
  logic                    in_map;
  desc_t                   desc;

  function automatic logic [ROW_CNT_W-1:0] clamp_row(input logic signed [CRD_W-1:0] v,
                                                     input logic signed [CRD_W-1:0] lim);
    logic [ROW_CNT_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > lim) begin
      r = lim[ROW_CNT_W-1:0];
    end else begin
      r = v[ROW_CNT_W-1:0];
    end
    return r;
  endfunction

  assign busy      = full_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    full_nxt = full_r;
    if (start && !full_r) begin
      full_nxt = 1'b1;
    end else if (full_r && !q_full) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r   <= 1'b0;
      width_r  <= MAP_WIDTH_RST;
      height_r <= MAP_HEIGHT_RST;
    end else begin
      full_r <= full_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_WIDTH:  width_r  <= cfg_wdata;
          REG_MAP_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !full_r) begin
      cmd_r <= in_data;
    end
  end

  always_comb begin
    cols   = (int'(width_r) > MAX_COLUMNS) ? COL_CNT_W'(MAX_COLUMNS) : COL_CNT_W'(width_r);
    rows   = (int'(height_r) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(height_r);
    cols_s = signed'(CRD_W'(cols));
    rows_s = signed'(CRD_W'(rows));
    x      = CRD_W'(cmd_r.pos_x);
    y      = CRD_W'(cmd_r.pos_y);
    w      = signed'(CRD_W'(cmd_r.rect_width));
    h      = signed'(CRD_W'(cmd_r.rect_height));
    r16    = signed'(CRD_W'(cmd_r.disc_radius[RAD_W-1:4]));
    rad_sq = RSQ_W'(cmd_r.disc_radius) * RSQ_W'(cmd_r.disc_radius);
    in_map = (x >= 0) && (x < cols_s) && (y >= 0) && (y < rows_s);

    desc.kind    = K_RECT;
    desc.value   = 1'b0;
    desc.row_lo  = '0;
    desc.row_hi  = '0;
    desc.col_lo  = x;
    desc.col_hi  = x + w;
    desc.col_max = cols;
    desc.cx      = x;
    desc.cy      = y;
    desc.lim     = rad_sq[RSQ_W-1:8];

    case (cmd_r.opcode)
      OP_QUERY: begin
        desc.kind = K_QUERY;
        if (in_map) begin
          desc.row_lo = clamp_row(y, rows_s);
          desc.row_hi = clamp_row(y + CRD_ONE, rows_s);
        end
      end
      OP_SET_POINT, OP_CLEAR_POINT: begin
        desc.value  = (cmd_r.opcode == OP_SET_POINT);
        desc.row_lo = clamp_row(y, rows_s);
        desc.row_hi = clamp_row(y + CRD_ONE, rows_s);
        desc.col_hi = x + CRD_ONE;
      end
      OP_FILL_RECT, OP_CLEAR_RECT: begin
        desc.value  = (cmd_r.opcode == OP_FILL_RECT);
        desc.row_lo = clamp_row(y, rows_s);
        desc.row_hi = clamp_row(y + h, rows_s);
      end
      OP_FILL_DISC, OP_CLEAR_DISC: begin
        desc.kind   = K_DISC;
        desc.value  = (cmd_r.opcode == OP_FILL_DISC);
        desc.row_lo = clamp_row(y - r16, rows_s);
        desc.row_hi = clamp_row(y + r16 + CRD_ONE, rows_s);
      end
      default: ;
    endcase
  end

  assign push.valid = full_r;
  assign push.desc  = desc;

endmodule

// ===== src/ogp_queue.sv =====
// Short descriptor queue between the front end and the painting engine.
// Depends on ogp_pkg.
module ogp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  ogp_pkg::push_t push,
  output logic           q_full,
  output logic           q_valid,
  output ogp_pkg::desc_t q_desc,
  input  logic           q_pop
);
  import ogp_pkg::*;

  desc_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = entry_r[rd_ptr_r];
  assign do_push = push.valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.desc;
    end
  end

endmodule

// ===== src/ogp_back.sv =====
// Painting engine: owns the row-wide grid memory and sweeps each descriptor
// row by row, with a bit-serial square root for disc spans. Depends on ogp_pkg.
module ogp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ogp_pkg::desc_t q_desc,
  output logic           q_pop,
  output logic           out_strobe,
  output ogp_pkg::res_t  out_data
);
  import ogp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROW   = 4'b0010,
    S_SQRT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  desc_t                   desc_r, desc_nxt;
  logic [ROW_CNT_W-1:0]    row_r, row_nxt;
  logic signed [CRD_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SQ_W-1:0]         sq_num_r, sq_num_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [MAX_COLUMNS-1:0]  mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]     row_valid_r;
  logic [MAX_COLUMNS-1:0]  rd_data_r, old_row, new_row, mask;
  logic                    rd_valid_r, rd_en, wr_en;
  logic [ROW_W-1:0]        addr;
  logic signed [CRD_W-1:0] dy;
  logic [DY_W-1:0]         dy_abs;
  logic [DSQ_W-1:0]        dy_sq;
  logic signed [T_W-1:0]   t_s;
  logic [SQ_W-1:0]         trial;
  logic                    sq_ge;
  logic [HW_W-1:0]         hw;
  logic                    emit, out_strobe_r;
  res_t                    emit_res, out_res_r;

  assign addr    = row_r[ROW_W-1:0];
  assign old_row = rd_valid_r ? rd_data_r : '0;

  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      mask[i] = (CRD_W'(i) >= lo_r) && (CRD_W'(i) < hi_r) &&
                (COL_CNT_W'(i) < desc_r.col_max);
    end
    new_row = desc_r.value ? (old_row | mask) : (old_row & ~mask);
  end

  always_comb begin
    dy     = signed'(CRD_W'(row_r)) - desc_r.cy;
    dy_abs = dy[CRD_W-1] ? DY_W'(-dy) : DY_W'(dy);
    dy_sq  = DSQ_W'(dy_abs) * DSQ_W'(dy_abs);
    t_s    = signed'(T_W'(desc_r.lim)) - signed'(T_W'(dy_sq));
    trial  = sq_res_r + sq_bit_r;
    sq_ge  = (sq_num_r >= trial);
  end

  always_comb begin
    state_nxt  = state_r;
    desc_nxt   = desc_r;
    row_nxt    = row_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    sq_num_nxt = sq_num_r;
    sq_res_nxt = sq_res_r;
    sq_bit_nxt = sq_bit_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    emit_res   = '0;
    hw         = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          desc_nxt  = q_desc;
          row_nxt   = q_desc.row_lo;
          lo_nxt    = q_desc.col_lo;
          hi_nxt    = q_desc.col_hi;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (row_r >= desc_r.row_hi) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (desc_r.kind == K_DISC) begin
          if (t_s[T_W-1]) begin
            row_nxt = row_r + ROW_CNT_W'(1);
          end else begin
            sq_num_nxt = SQ_W'(t_s[LIM_W-1:0]);
            sq_res_nxt = '0;
            sq_bit_nxt = SQ_BIT0;
            state_nxt  = S_SQRT;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          sq_num_nxt = sq_num_r - trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          hw        = sq_res_nxt[HW_W-1:0];
          lo_nxt    = desc_r.cx - signed'(CRD_W'(hw));
          hi_nxt    = desc_r.cx + signed'(CRD_W'(hw)) + CRD_ONE;
          rd_en     = 1'b1;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (desc_r.kind == K_QUERY) begin
          emit                = 1'b1;
          emit_res.inside_map = 1'b1;
          emit_res.walkable   = !old_row[desc_r.col_lo[COL_W-1:0]];
          state_nxt           = S_IDLE;
        end else begin
          wr_en     = 1'b1;
          row_nxt   = row_r + ROW_CNT_W'(1);
          state_nxt = S_ROW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_valid_r  <= '0;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit;
      if (wr_en) begin
        row_valid_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= row_valid_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    desc_r   <= desc_nxt;
    row_r    <= row_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    sq_num_r <= sq_num_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= new_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_res_r;

endmodule

// ===== src/occupancy_grid_painter.sv =====
// Occupancy grid painter top level: front end, descriptor queue and painting engine.
// A query's result follows the command register, the queue and the engine states.
// Busy is high from a command's transfer until the queue takes it, so commands can be taken
// while the engine paints; the engine visits each clipped rectangle row in its row and write
// states, and for a disc skips rows off it and sets each row span with a 7-step square root.
// Reset clears the whole grid at once through per-row valid bits; the size registers return to 64.
module occupancy_grid_painter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ogp_pkg::cmd_t                  in_data,
  output logic                           out_strobe,
  output ogp_pkg::res_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ogp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogp_pkg::SIZE_W-1:0]     cfg_wdata
);
  import ogp_pkg::*;

  push_t push;
  logic  q_full, q_valid, q_pop;
  desc_t q_desc;

  ogp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push)
  );

  ogp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .q_pop   (q_pop)
  );

  ogp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command transfer");

  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results issued on consecutive cycles");

  a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.walkable) |-> out_data.inside_map)
    else $error("walkable reported for a cell outside the map");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("activity right after reset");

endmodule
